// File: rtl/annexb_to_length_prefix_nal_scanner_defines.svh
// Assertion helpers for the start-code scanner.
// All checks are sampled on clk_i and disabled while rst_ni is low.
`ifndef ANNEXB_TO_LENGTH_PREFIX_NAL_SCANNER_DEFINES_SVH
`define ANNEXB_TO_LENGTH_PREFIX_NAL_SCANNER_DEFINES_SVH

// A plain property on the block clock.
`define ANLPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication: when ante holds, cons holds in the same cycle.
`define ANLPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/anlps_pkg.sv
`default_nettype none

package anlps_pkg;

  // Bytes in each length field.
  localparam logic [31:0] LenFieldBytes = 32'd4;
  // Reset value of base_offset (box header size).
  localparam logic [31:0] BaseOffsetRst = 32'd8;

  localparam logic [7:0] ZeroByte = 8'h00;
  localparam logic [7:0] CodeByte = 8'h01;

  // Zero run length, saturating.
  localparam logic [1:0] RunNone = 2'd0;
  localparam logic [1:0] RunOne  = 2'd1;
  localparam logic [1:0] RunTwo  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
    logic       unit_end;
  } in_item_t;

  typedef struct packed {
    logic        nal_valid;
    logic [31:0] nal_source_offset;
    logic [31:0] nal_length;
    logic [31:0] record_offset;
    logic        unit_done;
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
  } out_item_t;

  // Scanner to accounting: what one byte produced.
  typedef struct packed {
    logic        emit;
    logic [31:0] src;
    logic [31:0] len;
    logic        uend;
  } nal_evt_t;

endpackage

`default_nettype wire

// File: rtl/anlps_scan.sv
`default_nettype none

`include "annexb_to_length_prefix_nal_scanner_defines.svh"

module anlps_scan (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire anlps_pkg::in_item_t item_i,
  output anlps_pkg::nal_evt_t    evt_o
);

  logic [31:0] pos_q, pos_d;
  logic [1:0]  run_cnt_q, run_cnt_d;
  logic [31:0] run_start_q, run_start_d;
  logic        nal_open_q, nal_open_d;
  logic [31:0] nal_start_q, nal_start_d;

  logic        is_zero, is_code, bend;

  always_comb begin
    is_zero = (item_i.data_byte == anlps_pkg::ZeroByte);
    is_code = (item_i.data_byte == anlps_pkg::CodeByte) && (run_cnt_q == anlps_pkg::RunTwo);
    bend    = item_i.buffer_end;

    pos_d       = pos_q + 32'd1;
    run_cnt_d   = run_cnt_q;
    run_start_d = run_start_q;
    nal_open_d  = nal_open_q;
    nal_start_d = nal_start_q;

    evt_o.emit = 1'b0;
    evt_o.src  = nal_start_q;
    evt_o.len  = '0;
    evt_o.uend = bend && item_i.unit_end;

    if (is_zero) begin
      if (run_cnt_q == anlps_pkg::RunNone) run_start_d = pos_q;
      if (run_cnt_q != anlps_pkg::RunTwo) run_cnt_d = run_cnt_q + 2'd1;
    end else if (is_code) begin
      // start code closes the open unit; payload ends where the zero run began
      evt_o.emit  = nal_open_q;
      evt_o.len   = run_start_q - nal_start_q;
      nal_open_d  = 1'b1;
      nal_start_d = pos_q + 32'd1;
      run_cnt_d   = anlps_pkg::RunNone;
    end else begin
      run_cnt_d = anlps_pkg::RunNone;
    end

    // last unit of the buffer runs to its end, trailing zeros included
    if (bend && nal_open_q && !is_code) begin
      evt_o.emit = 1'b1;
      evt_o.len  = pos_q + 32'd1 - nal_start_q;
    end

    if (bend) begin
      pos_d      = '0;
      run_cnt_d  = anlps_pkg::RunNone;
      nal_open_d = 1'b0;
    end

    if (!evt_o.emit) evt_o.len = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      run_cnt_q   <= anlps_pkg::RunNone;
      run_start_q <= '0;
      nal_open_q  <= 1'b0;
      nal_start_q <= '0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      run_cnt_q   <= run_cnt_d;
      run_start_q <= run_start_d;
      nal_open_q  <= nal_open_d;
      nal_start_q <= nal_start_d;
    end
  end

  `ANLPS_ASSERT(a_run_cnt_sat, run_cnt_q != 2'd3, "zero run count past saturation")
  `ANLPS_ASSERT_IMPL(a_bend_closes, $past(step_i && item_i.buffer_end),
                     !nal_open_q && (pos_q == 32'd0), "buffer end left state open")

endmodule

`default_nettype wire

// File: rtl/anlps_acct.sv
`default_nettype none

`include "annexb_to_length_prefix_nal_scanner_defines.svh"

module anlps_acct (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire logic                step_i,
  input  wire anlps_pkg::nal_evt_t evt_i,
  output logic                     has_result_o,
  output anlps_pkg::out_item_t     res_o
);

  logic [31:0] base_q;
  logic [31:0] wr_off_q, wr_off_d;
  logic [31:0] unit_start_q, unit_start_eff;
  logic [31:0] unit_total_q, unit_total_d;
  logic        unit_fresh_q;
  logic [31:0] rec_len;

  always_comb begin
    unit_start_eff = unit_fresh_q ? wr_off_q : unit_start_q;
    rec_len        = evt_i.len + anlps_pkg::LenFieldBytes;
    wr_off_d       = evt_i.emit ? wr_off_q + rec_len : wr_off_q;
    unit_total_d   = evt_i.emit ? unit_total_q + rec_len : unit_total_q;

    has_result_o = evt_i.emit || evt_i.uend;

    res_o = '0;
    if (evt_i.emit) begin
      res_o.nal_valid         = 1'b1;
      res_o.nal_source_offset = evt_i.src;
      res_o.nal_length        = evt_i.len;
      res_o.record_offset     = base_q + wr_off_q;
    end
    if (evt_i.uend) begin
      res_o.unit_done   = 1'b1;
      res_o.unit_offset = base_q + unit_start_eff;
      res_o.unit_length = unit_total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= anlps_pkg::BaseOffsetRst;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_off_q     <= '0;
      unit_start_q <= '0;
      unit_total_q <= '0;
      unit_fresh_q <= 1'b1;
    end else if (step_i) begin
      wr_off_q     <= wr_off_d;
      unit_start_q <= unit_start_eff;
      unit_total_q <= evt_i.uend ? 32'd0 : unit_total_d;
      unit_fresh_q <= evt_i.uend;
    end
  end

  `ANLPS_ASSERT_IMPL(a_unit_cleared, $past(step_i && evt_i.uend),
                     unit_fresh_q && (unit_total_q == 32'd0), "unit totals not cleared")

endmodule

`default_nettype wire

// File: rtl/annexb_to_length_prefix_nal_scanner.sv
// Channel  Signals                          Moves
// -------  -------------------------------  -------------------------------------
// in       in_valid_i / in_ready_o          one stream byte + buffer/unit marks
// out      out_valid_o / out_ready_i        one NAL and/or access-unit record
// cfg      cfg_we_i / cfg_wdata_i           base_offset, written on we, no wait
//
// One byte per cycle sustained while no record waits for out_ready_i. A byte
// is held in the input register, then scan + offset math runs in one pass
// into the result register.
// Bytes that produce no record update state and vanish without an output slot.
// The result register stalls the pipe only while a record waits for out_ready_i;
// the input side keeps taking a transaction into the empty input register then.
// Reset clears all scan and accounting state; base_offset resets to 8.
`default_nettype none

`include "annexb_to_length_prefix_nal_scanner_defines.svh"

module annexb_to_length_prefix_nal_scanner (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input byte stream
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire anlps_pkg::in_item_t  in_data_i,
  // result records
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output anlps_pkg::out_item_t      out_data_o,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_wdata_i
);

  // input register
  logic                 s1_valid_q;
  anlps_pkg::in_item_t  s1_item_q;

  // result register
  logic                 out_valid_q;
  anlps_pkg::out_item_t out_item_q;

  logic                 out_free;   // result register can take a record
  logic                 step;       // byte in s1 is processed this cycle
  anlps_pkg::nal_evt_t  evt;
  logic                 has_result;
  anlps_pkg::out_item_t res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  // input register frees up whenever its byte is processed
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
  end

  anlps_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item_q),
    .evt_o  (evt)
  );

  anlps_acct u_acct (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (step),
    .evt_i        (evt),
    .has_result_o (has_result),
    .res_o        (res)
  );

  // result register: loads only on a processed byte that yields a record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_result) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  `ANLPS_ASSERT_IMPL(a_out_from_step, $rose(out_valid_q), $past(step && has_result),
                     "record appeared without a processed byte")

endmodule

`default_nettype wire
